[rtl/core/order_command_line_parser_core_assert.svh]
// Assertion macros used by the parser core RTL.
`ifndef ORDER_COMMAND_LINE_PARSER_CORE_ASSERT_SVH
`define ORDER_COMMAND_LINE_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OCP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define OCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OCP_ASSERT(lbl, clk, rst, prop, msg)
`define OCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/ocp_pkg.sv]
// ----------------------------------------------------------------------------
// ocp_pkg
// Codes, keyword tables and per-command argument roles of the order parser.
// ----------------------------------------------------------------------------
package ocp_pkg;

  localparam int ID_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF = 48;

  localparam logic [2:0] CMD_PING   = 3'd0;
  localparam logic [2:0] CMD_QUOTE  = 3'd1;
  localparam logic [2:0] CMD_NEW    = 3'd2;
  localparam logic [2:0] CMD_CANCEL = 3'd3;
  localparam logic [2:0] CMD_MODIFY = 3'd4;
  localparam logic [2:0] CMD_NONE   = 3'd7;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_EMPTY      = 4'd1;
  localparam logic [3:0] ST_NO_TOKENS  = 4'd2;
  localparam logic [3:0] ST_MISSING    = 4'd3;
  localparam logic [3:0] ST_BAD_INSTR  = 4'd4;
  localparam logic [3:0] ST_BAD_TRADER = 4'd5;
  localparam logic [3:0] ST_BAD_SIDE   = 4'd6;
  localparam logic [3:0] ST_BAD_PRICE  = 4'd7;
  localparam logic [3:0] ST_BAD_QTY    = 4'd8;
  localparam logic [3:0] ST_BAD_TIF    = 4'd9;
  localparam logic [3:0] ST_BAD_ORDER  = 4'd10;
  localparam logic [3:0] ST_UNKNOWN    = 4'd11;

  localparam logic [1:0] TIF_GTC = 2'd0;
  localparam logic [1:0] TIF_IOC = 2'd1;
  localparam logic [1:0] TIF_FOK = 2'd2;

  // Keyword slots: command keywords, then the time-in-force words.
  localparam logic [2:0] KW_IOC = 3'd5;
  localparam logic [2:0] KW_FOK = 3'd6;
  localparam logic [2:0] KW_GTC = 3'd7;

  typedef enum logic [3:0] {
    ROLE_NONE, ROLE_INSTR, ROLE_TRADER, ROLE_SIDE, ROLE_PRICE_U,
    ROLE_QTY, ROLE_TIF, ROLE_ORDER, ROLE_PRICE_S
  } role_t;

  // Summary of the token held by the scanner, used when it closes.
  typedef struct packed {
    logic       close;
    logic [2:0] pos;
    logic [7:0] cand;
    logic       bad;
    logic       neg;
    logic       dig;
    logic       big;
  } tok_t;

  function automatic logic [2:0] kw_len(input logic [2:0] idx);
    logic [2:0] l;
    unique case (idx)
      3'd0:    l = 3'd4;
      3'd1:    l = 3'd5;
      3'd2:    l = 3'd3;
      3'd3:    l = 3'd6;
      3'd4:    l = 3'd6;
      default: l = 3'd3;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [47:0] w;
    logic [47:0] s;
    unique case (idx)
      3'd0:    w = {"PING", 16'h0};
      3'd1:    w = {"QUOTE", 8'h0};
      3'd2:    w = {"NEW", 24'h0};
      3'd3:    w = "CANCEL";
      3'd4:    w = "MODIFY";
      3'd5:    w = {"IOC", 24'h0};
      3'd6:    w = {"FOK", 24'h0};
      default: w = {"GTC", 24'h0};
    endcase
    s = w << {pos, 3'b000};
    return (pos > 3'd5) ? 8'h00 : s[47:40];
  endfunction

  function automatic logic [2:0] cmd_need(input logic [2:0] cmd);
    logic [2:0] n;
    unique case (cmd)
      CMD_PING:   n = 3'd1;
      CMD_QUOTE:  n = 3'd2;
      CMD_NEW:    n = 3'd6;
      CMD_CANCEL: n = 3'd3;
      default:    n = 3'd5;
    endcase
    return n;
  endfunction

  function automatic role_t role_of(input logic [2:0] cmd, input logic [2:0] idx);
    role_t r;
    r = ROLE_NONE;
    if (idx == 3'd1 && cmd != CMD_PING) begin
      r = ROLE_INSTR;
    end else if (cmd == CMD_NEW) begin
      unique case (idx)
        3'd2:    r = ROLE_TRADER;
        3'd3:    r = ROLE_SIDE;
        3'd4:    r = ROLE_PRICE_U;
        3'd5:    r = ROLE_QTY;
        3'd6:    r = ROLE_TIF;
        default: r = ROLE_NONE;
      endcase
    end else if (cmd == CMD_CANCEL || cmd == CMD_MODIFY) begin
      unique case (idx)
        3'd2:    r = ROLE_ORDER;
        3'd3:    r = (cmd == CMD_MODIFY) ? ROLE_QTY : ROLE_NONE;
        3'd4:    r = (cmd == CMD_MODIFY) ? ROLE_PRICE_S : ROLE_NONE;
        default: r = ROLE_NONE;
      endcase
    end
    return r;
  endfunction

  function automatic logic [3:0] role_err(input role_t r);
    logic [3:0] e;
    unique case (r)
      ROLE_INSTR:   e = ST_BAD_INSTR;
      ROLE_TRADER:  e = ST_BAD_TRADER;
      ROLE_SIDE:    e = ST_BAD_SIDE;
      ROLE_PRICE_U: e = ST_BAD_PRICE;
      ROLE_QTY:     e = ST_BAD_QTY;
      ROLE_TIF:     e = ST_BAD_TIF;
      ROLE_ORDER:   e = ST_BAD_ORDER;
      ROLE_PRICE_S: e = ST_BAD_PRICE;
      default:      e = ST_OK;
    endcase
    return e;
  endfunction

endpackage

[rtl/core/ocp_in_if.sv]
// ----------------------------------------------------------------------------
// ocp_in_if
// Byte channel carrying one command character or an end-of-line mark.
// ----------------------------------------------------------------------------
interface ocp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_line;

  modport source (output valid, data_byte, end_of_line, input ready);
  modport sink (input valid, data_byte, end_of_line, output ready);
endinterface

[rtl/core/ocp_out_if.sv]
// ----------------------------------------------------------------------------
// ocp_out_if
// Record channel carrying one parsed command per line.
// ----------------------------------------------------------------------------
interface ocp_out_if #(
  parameter int ID_BITS    = 32,
  parameter int VALUE_BITS = 48
);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   status;
  logic [2:0]                   command;
  logic [ID_BITS-1:0]           instrument;
  logic [ID_BITS-1:0]           trader;
  logic                         sell_side;
  logic signed [VALUE_BITS-1:0] price_ticks;
  logic [VALUE_BITS-2:0]        quantity;
  logic [1:0]                   time_in_force;
  logic [ID_BITS-1:0]           order_ref;

  modport source (output valid, status, command, instrument, trader, sell_side,
                  price_ticks, quantity, time_in_force, order_ref, input ready);
  modport sink (input valid, status, command, instrument, trader, sell_side,
                price_ticks, quantity, time_in_force, order_ref, output ready);
endinterface

[rtl/core/order_command_line_parser_core.sv]
// ----------------------------------------------------------------------------
// order_command_line_parser_core
// Parses text order commands byte by byte and emits one record per line.
// ----------------------------------------------------------------------------
// Channel  | Direction | Word
// cmd_in   | sink      | data_byte, end_of_line
// rec_out  | source    | status, command, ids, side, price, quantity, tif
//
// One word is taken every cycle unless an end-of-line word is held back by a
// stalled record; a word sits in the input register while the scan/line logic
// works on it. The line state and, for an end-of-line word, the output
// register are loaded as the word leaves the input register.
// Reset is synchronous and clears the line state.
// A stalled record holds back only an end-of-line word; character words
// keep flowing while it waits.
`include "order_command_line_parser_core_assert.svh"

module order_command_line_parser_core
  import ocp_pkg::*;
#(
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  ocp_in_if.sink      cmd_in,
  ocp_out_if.source   rec_out
);

  localparam int ACC_BITS = (ID_BITS > VALUE_BITS) ? ID_BITS : VALUE_BITS;

  logic                         in_v;
  logic [7:0]                   in_byte;
  logic                         in_eol;
  logic                         step;
  logic                         out_v;
  tok_t                         tok;
  logic [ACC_BITS-1:0]          acc;
  logic [3:0]                   r_status;
  logic [2:0]                   r_command;
  logic [ID_BITS-1:0]           r_instr, r_trader, r_order;
  logic                         r_side;
  logic signed [VALUE_BITS-1:0] r_price;
  logic [VALUE_BITS-2:0]        r_qty;
  logic [1:0]                   r_tif;

  assign step         = in_v && (!in_eol || !out_v || rec_out.ready);
  assign cmd_in.ready = !in_v || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (cmd_in.valid && cmd_in.ready) begin
      in_v <= 1'b1;
    end else if (step) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.valid && cmd_in.ready) begin
      in_byte <= cmd_in.data_byte;
      in_eol  <= cmd_in.end_of_line;
    end
  end

  ocp_scan #(.ACC_BITS(ACC_BITS)) u_scan (
    .clk(clk), .rst(rst), .step(step), .data_byte(in_byte), .end_of_line(in_eol),
    .tok(tok), .acc(acc)
  );

  ocp_line #(.ID_BITS(ID_BITS), .VALUE_BITS(VALUE_BITS), .ACC_BITS(ACC_BITS)) u_line (
    .clk(clk), .rst(rst), .step(step), .end_of_line(in_eol), .tok(tok), .acc(acc),
    .status(r_status), .command(r_command), .instrument(r_instr), .trader(r_trader),
    .sell_side(r_side), .price_ticks(r_price), .quantity(r_qty),
    .time_in_force(r_tif), .order_ref(r_order)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (step && in_eol) begin
      out_v <= 1'b1;
    end else if (rec_out.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_eol) begin
      rec_out.status        <= r_status;
      rec_out.command       <= r_command;
      rec_out.instrument    <= r_instr;
      rec_out.trader        <= r_trader;
      rec_out.sell_side     <= r_side;
      rec_out.price_ticks   <= r_price;
      rec_out.quantity      <= r_qty;
      rec_out.time_in_force <= r_tif;
      rec_out.order_ref     <= r_order;
    end
  end

  assign rec_out.valid = out_v;

  `OCP_ASSERT_NEXT(a_eol_gives_record, clk, rst, step && in_eol, out_v, "end of line lost its record")
  `OCP_ASSERT_NEXT(a_no_phantom, clk, rst, out_v && rec_out.ready && !(step && in_eol), !out_v, "record repeated")
  `OCP_ASSERT(a_ok_cmd, clk, rst, !(out_v && rec_out.status == ST_OK) || rec_out.command <= CMD_MODIFY, "ok record with bad command")
  `OCP_ASSERT(a_eol_stall, clk, rst, !(in_v && in_eol && out_v && !rec_out.ready) || !step, "end of line overran record")

endmodule

[rtl/core/ocp_scan.sv]
// ----------------------------------------------------------------------------
// ocp_scan
// Token scanner: keyword candidate tracking and decimal accumulation.
// ----------------------------------------------------------------------------
module ocp_scan
  import ocp_pkg::*;
#(
  parameter int ACC_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                end_of_line,
  output tok_t                tok,
  output logic [ACC_BITS-1:0] acc
);

  logic                in_token;
  logic [2:0]          pos;
  logic [7:0]          cand;
  logic                bad, neg, dig, big;

  logic                is_space, fresh;
  logic [7:0]          up;
  logic [2:0]          bpos;
  logic [7:0]          bcand;
  logic [ACC_BITS-1:0] bacc;
  logic                bbad, bneg, bdig, bbig;
  logic [7:0]          cand_next;
  logic [ACC_BITS-1:0] acc_next;
  logic                bad_next, neg_next, dig_next, big_next;
  logic [2:0]          pos_next;
  logic [ACC_BITS+3:0] prod;

  always_comb begin
    is_space = (data_byte == 8'd32) || (data_byte >= 8'd9 && data_byte <= 8'd13);
    up       = (data_byte >= "a" && data_byte <= "z") ? data_byte - 8'd32 : data_byte;
    fresh    = !in_token;
    bpos     = fresh ? 3'd0 : pos;
    bcand    = fresh ? 8'hFF : cand;
    bacc     = fresh ? '0 : acc;
    bbad     = fresh ? 1'b0 : bad;
    bneg     = fresh ? 1'b0 : neg;
    bdig     = fresh ? 1'b0 : dig;
    bbig     = fresh ? 1'b0 : big;
    for (int i = 0; i < 8; i++) begin
      cand_next[i] = bcand[i] && (bpos < kw_len(3'(i))) && (kw_char(3'(i), bpos) == up);
    end
    // Times ten by shift and add; any carry into the top bits exceeds every field.
    prod = {1'b0, bacc, 3'b000} + {3'b000, bacc, 1'b0} + (ACC_BITS+4)'(data_byte[3:0]);
    acc_next = bacc;
    bad_next = bbad;
    neg_next = bneg;
    dig_next = bdig;
    big_next = bbig;
    if (data_byte == "-" && bpos == 3'd0) begin
      neg_next = 1'b1;
    end else if (data_byte >= "0" && data_byte <= "9") begin
      dig_next = 1'b1;
      if (!bbig) begin
        if (prod[ACC_BITS+3:ACC_BITS] != 4'd0) begin
          big_next = 1'b1;
        end else begin
          acc_next = prod[ACC_BITS-1:0];
        end
      end
    end else begin
      bad_next = 1'b1;
    end
    pos_next = (bpos == 3'd7) ? bpos : bpos + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token <= 1'b0;
      pos      <= 3'd0;
      cand     <= 8'hFF;
      acc      <= '0;
      bad      <= 1'b0;
      neg      <= 1'b0;
      dig      <= 1'b0;
      big      <= 1'b0;
    end else if (step) begin
      if (end_of_line) begin
        in_token <= 1'b0;
        pos      <= 3'd0;
        cand     <= 8'hFF;
        acc      <= '0;
        bad      <= 1'b0;
        neg      <= 1'b0;
        dig      <= 1'b0;
        big      <= 1'b0;
      end else if (is_space) begin
        in_token <= 1'b0;
      end else begin
        in_token <= 1'b1;
        pos      <= pos_next;
        cand     <= cand_next;
        acc      <= acc_next;
        bad      <= bad_next;
        neg      <= neg_next;
        dig      <= dig_next;
        big      <= big_next;
      end
    end
  end

  always_comb begin
    tok.close = step && in_token && (end_of_line || is_space);
    tok.pos   = pos;
    tok.cand  = cand;
    tok.bad   = bad;
    tok.neg   = neg;
    tok.dig   = dig;
    tok.big   = big;
  end

endmodule

[rtl/core/ocp_line.sv]
// ----------------------------------------------------------------------------
// ocp_line
// Line state: keyword decode, argument checks, staged fields and the record.
// ----------------------------------------------------------------------------
module ocp_line
  import ocp_pkg::*;
#(
  parameter int ID_BITS    = 32,
  parameter int VALUE_BITS = 48,
  parameter int ACC_BITS   = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         end_of_line,
  input  tok_t                         tok,
  input  logic [ACC_BITS-1:0]          acc,
  output logic [3:0]                   status,
  output logic [2:0]                   command,
  output logic [ID_BITS-1:0]           instrument,
  output logic [ID_BITS-1:0]           trader,
  output logic                         sell_side,
  output logic signed [VALUE_BITS-1:0] price_ticks,
  output logic [VALUE_BITS-2:0]        quantity,
  output logic [1:0]                   time_in_force,
  output logic [ID_BITS-1:0]           order_ref
);

  localparam logic [ACC_BITS-1:0] ID_MAX = ACC_BITS'({ID_BITS{1'b1}});
  localparam logic [ACC_BITS-1:0] V_MAX  = ACC_BITS'({(VALUE_BITS-1){1'b1}});

  logic                  has_bytes;
  logic [2:0]            cnt;
  logic [2:0]            cmd;
  logic [3:0]            err;
  logic [1:0]            tif;
  logic [ID_BITS-1:0]    f_instr, f_trader, f_order;
  logic                  f_side;
  logic [VALUE_BITS-1:0] f_price;
  logic [VALUE_BITS-2:0] f_qty;

  logic [2:0]            cnt_next, cmd_next;
  logic [3:0]            err_next;
  logic [1:0]            tif_next;
  logic [ID_BITS-1:0]    instr_next, trader_next, order_next;
  logic                  side_next;
  logic [VALUE_BITS-1:0] price_next;
  logic [VALUE_BITS-2:0] qty_next;

  role_t                 role;
  logic                  plain, ok, found;
  logic [ACC_BITS-1:0]   neg_acc;

  always_comb begin
    cnt_next    = cnt;
    cmd_next    = cmd;
    err_next    = err;
    tif_next    = tif;
    instr_next  = f_instr;
    trader_next = f_trader;
    order_next  = f_order;
    side_next   = f_side;
    price_next  = f_price;
    qty_next    = f_qty;
    found       = 1'b0;
    ok          = 1'b1;
    plain       = !tok.bad && !tok.big && tok.dig;
    neg_acc     = '0 - acc;
    role        = role_of(cmd, cnt);
    if (tok.close) begin
      if (cnt == 3'd0) begin
        for (int i = 0; i < 5; i++) begin
          if (!found && tok.cand[i] && tok.pos == kw_len(3'(i))) begin
            found    = 1'b1;
            cmd_next = 3'(i);
          end
        end
      end else if (cnt != 3'd7 && cmd != CMD_NONE) begin
        unique case (role)
          ROLE_INSTR, ROLE_TRADER, ROLE_ORDER: begin
            ok = plain && !tok.neg && acc <= ID_MAX;
            if (ok) begin
              if (role == ROLE_INSTR) instr_next = acc[ID_BITS-1:0];
              else if (role == ROLE_TRADER) trader_next = acc[ID_BITS-1:0];
              else order_next = acc[ID_BITS-1:0];
            end
          end
          ROLE_SIDE: begin
            ok = !tok.bad && !tok.neg && tok.dig;
            if (ok) side_next = tok.big || (acc != '0);
          end
          ROLE_PRICE_U, ROLE_QTY: begin
            ok = plain && !tok.neg && acc <= V_MAX;
            if (ok) begin
              if (role == ROLE_QTY) qty_next = acc[VALUE_BITS-2:0];
              else price_next = acc[VALUE_BITS-1:0];
            end
          end
          ROLE_PRICE_S: begin
            ok = plain && (tok.neg ? acc <= V_MAX + ACC_BITS'(1) : acc <= V_MAX);
            if (ok) price_next = tok.neg ? neg_acc[VALUE_BITS-1:0] : acc[VALUE_BITS-1:0];
          end
          ROLE_TIF: begin
            priority if (tok.cand[KW_IOC] && tok.pos == kw_len(KW_IOC)) begin
              tif_next = TIF_IOC;
            end else if (tok.cand[KW_FOK] && tok.pos == kw_len(KW_FOK)) begin
              tif_next = TIF_FOK;
            end else if (tok.cand[KW_GTC] && tok.pos == kw_len(KW_GTC)) begin
              tif_next = TIF_GTC;
            end else begin
              ok = 1'b0;
            end
          end
          default: ok = 1'b1;
        endcase
        if (!ok && err == ST_OK) err_next = role_err(role);
      end
      if (cnt != 3'd7) cnt_next = cnt + 3'd1;
    end
  end

  // Record as seen by an end-of-line word, after closing any open token.
  always_comb begin
    priority if (!has_bytes) begin
      status = ST_EMPTY;
    end else if (cnt_next == 3'd0) begin
      status = ST_NO_TOKENS;
    end else if (cmd_next == CMD_NONE) begin
      status = ST_UNKNOWN;
    end else if (cnt_next < cmd_need(cmd_next)) begin
      status = ST_MISSING;
    end else begin
      status = err_next;
    end
    command       = (cmd_next == CMD_NONE) ? CMD_PING : cmd_next;
    instrument    = (status == ST_OK) ? instr_next : '0;
    trader        = (status == ST_OK) ? trader_next : '0;
    sell_side     = (status == ST_OK) && side_next;
    price_ticks   = (status == ST_OK) ? price_next : '0;
    quantity      = (status == ST_OK) ? qty_next : '0;
    time_in_force = (status == ST_OK) ? tif_next : TIF_GTC;
    order_ref     = (status == ST_OK) ? order_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_bytes <= 1'b0;
      cnt       <= 3'd0;
      cmd       <= CMD_NONE;
      err       <= ST_OK;
      tif       <= TIF_GTC;
      f_instr   <= '0;
      f_trader  <= '0;
      f_order   <= '0;
      f_side    <= 1'b0;
      f_price   <= '0;
      f_qty     <= '0;
    end else if (step) begin
      if (end_of_line) begin
        has_bytes <= 1'b0;
        cnt       <= 3'd0;
        cmd       <= CMD_NONE;
        err       <= ST_OK;
        tif       <= TIF_GTC;
        f_instr   <= '0;
        f_trader  <= '0;
        f_order   <= '0;
        f_side    <= 1'b0;
        f_price   <= '0;
        f_qty     <= '0;
      end else begin
        has_bytes <= 1'b1;
        cnt       <= cnt_next;
        cmd       <= cmd_next;
        err       <= err_next;
        tif       <= tif_next;
        f_instr   <= instr_next;
        f_trader  <= trader_next;
        f_order   <= order_next;
        f_side    <= side_next;
        f_price   <= price_next;
        f_qty     <= qty_next;
      end
    end
  end

endmodule
